// ===== rtl/core/lcom_pkg.sv =====
`default_nettype none

package lcom_pkg;

  // field widths
  localparam int RNGW  = 18;
  localparam int COLW  = 11;
  localparam int GAPW  = 16;
  localparam int DIVW  = 10;
  localparam int PRODW = RNGW + DIVW;
  localparam int WSW   = 22;
  localparam int IDXW  = 16;
  localparam int CURVW = 43;
  localparam int SQW   = 2 * WSW;

  // window geometry
  localparam int HALF  = 5;
  localparam int LAG   = 6;
  localparam int NCELL = 2 * HALF + 1;

  // configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  localparam logic [1:0] REG_OCC_GAP = 2'd0;
  localparam logic [1:0] REG_PAR_DIV = 2'd1;
  localparam logic [1:0] REG_COL_GAP = 2'd2;
  localparam logic [GAPW-1:0] OCC_GAP_RST = 16'd300;
  localparam logic [DIVW-1:0] PAR_DIV_RST = 10'd50;
  localparam logic [COLW-1:0] COL_GAP_RST = 11'd10;

  typedef logic [RNGW-1:0]  rng_t;
  typedef logic [COLW-1:0]  col_t;
  typedef logic [GAPW-1:0]  gap_t;
  typedef logic [DIVW-1:0]  div_t;
  typedef logic [PRODW-1:0] prod_t;
  typedef logic [WSW-1:0]   wsum_t;
  typedef logic [IDXW-1:0]  idx_t;
  typedef logic [CURVW-1:0] curv_t;
  typedef logic [SQW-1:0]   sq_t;

  typedef struct packed {
    gap_t occ_gap;
    div_t par_div;
    col_t col_gap;
  } cfg_t;

  // word leaving the front stages
  typedef struct packed {
    rng_t  rng;
    prod_t prod;
    logic  last;
    logic  fall;
    logic  rise;
  } fitem_t;

  // one window cell
  typedef struct packed {
    rng_t rng;
    logic excl;
  } cell_t;

  // per-result side data
  typedef struct packed {
    idx_t index;
    logic cvalid;
    logic excl;
    logic last;
  } meta_t;

  // word handed from the window to the curvature pipeline
  typedef struct packed {
    rng_t  centre;
    wsum_t wsum;
    meta_t meta;
  } emit_t;

endpackage

`default_nettype wire

// ===== rtl/core/lcom_if.sv =====
`default_nettype none

interface lcom_in_if import lcom_pkg::*; ();
  logic valid;
  logic ready;
  rng_t range_mm;
  col_t column;
  logic last_point;

  modport source (output valid, output range_mm, output column, output last_point,
                  input ready);
  modport sink (input valid, input range_mm, input column, input last_point,
                output ready);
endinterface

interface lcom_out_if import lcom_pkg::*; ();
  logic  valid;
  logic  ready;
  idx_t  point_index;
  curv_t curvature;
  logic  curvature_valid;
  logic  excluded;
  logic  last_result;

  modport source (output valid, output point_index, output curvature,
                  output curvature_valid, output excluded, output last_result,
                  input ready);
  modport sink (input valid, input point_index, input curvature,
                input curvature_valid, input excluded, input last_result,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lcom_front.sv =====
`default_nettype none

module lcom_front import lcom_pkg::*; #(
  parameter int MAX_COLUMNS = 2048
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire cfg_t   cfg,
  lcom_in_if.sink     in_pt,
  output logic        f_valid,
  input  wire logic   f_take,
  output fitem_t      f_item
);

  logic v1_r, v2_r, v3_r;
  logic free1, free2, free3;

  rng_t r1_r, r2_r;
  col_t c1_r;
  logic l1_r, l2_r;
  rng_t diff2_r;
  logic fall2_r, rise2_r;
  fitem_t item3_r;

  rng_t prv_rng_r;
  col_t prv_col_r;

  col_t col_cl;
  col_t cdiff;
  rng_t rdiff;
  logic near, fall_nxt, rise_nxt;

  // stage handshake, bubbles collapse
  assign free3 = !v3_r || f_take;
  assign free2 = !v2_r || free3;
  assign free1 = !v1_r || free2;
  assign in_pt.ready = free1;

  // clamp column into the image
  assign col_cl = ({1'b0, in_pt.column} >= (COLW + 1)'(MAX_COLUMNS)) ?
                  COLW'(MAX_COLUMNS - 1) : in_pt.column;

  // pair terms against the previous word
  always_comb begin
    cdiff = (c1_r >= prv_col_r) ? c1_r - prv_col_r : prv_col_r - c1_r;
    rdiff = (r1_r >= prv_rng_r) ? r1_r - prv_rng_r : prv_rng_r - r1_r;
    near = cdiff < cfg.col_gap;
    fall_nxt = near && ({1'b0, prv_rng_r} > ({1'b0, r1_r} + (RNGW + 1)'(cfg.occ_gap)));
    rise_nxt = near && ({1'b0, r1_r} > ({1'b0, prv_rng_r} + (RNGW + 1)'(cfg.occ_gap)));
  end

  // valid bits and previous word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      prv_rng_r <= '0;
      prv_col_r <= '0;
    end else begin
      if (free1) v1_r <= in_pt.valid;
      if (free2) v2_r <= v1_r;
      if (free3) v3_r <= v2_r;
      if (free2 && v1_r) begin
        prv_rng_r <= r1_r;
        prv_col_r <= c1_r;
      end
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (free1 && in_pt.valid) begin
      r1_r <= in_pt.range_mm;
      c1_r <= col_cl;
      l1_r <= in_pt.last_point;
    end
    if (free2 && v1_r) begin
      r2_r <= r1_r;
      l2_r <= l1_r;
      diff2_r <= rdiff;
      fall2_r <= fall_nxt;
      rise2_r <= rise_nxt;
    end
    if (free3 && v2_r) begin
      item3_r.rng  <= r2_r;
      item3_r.prod <= PRODW'(diff2_r) * PRODW'(cfg.par_div);
      item3_r.last <= l2_r;
      item3_r.fall <= fall2_r;
      item3_r.rise <= rise2_r;
    end
  end

  assign f_valid = v3_r;
  assign f_item = item3_r;

endmodule

`default_nettype wire

// ===== rtl/core/lcom_cell.sv =====
`default_nettype none

module lcom_cell import lcom_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  shift,
  input  wire logic  clr,
  input  wire cell_t d,
  input  wire logic  mark,
  output cell_t      q
);

  cell_t q_r;
  cell_t q_nxt;

  // take the neighbor's point, or a mark on top of it
  always_comb begin
    q_nxt.rng  = d.rng;
    q_nxt.excl = d.excl | mark;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (clr) begin
      q_r <= '0;
    end else if (shift) begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ===== rtl/core/lcom_chain.sv =====
`default_nettype none

module lcom_chain import lcom_pkg::*; #(
  parameter int MAX_POINTS = 65536
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   f_valid,
  output logic        f_take,
  input  wire fitem_t f_item,
  output logic        em_valid,
  input  wire logic   em_ready,
  output emit_t       em
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int SW = CW + 1;

  cell_t cq [NCELL];
  cell_t cd [NCELL];
  logic [NCELL-1:0] mk;

  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_inc;
  logic fl_r;
  logic [2:0] fd_r;
  logic [HALF-1:0] pend_r;
  wsum_t wsum_r;
  wsum_t wsum_nxt;
  prod_t prodp_r;

  logic step_n, fstep, shift, fend;
  logic pair_ok, fall, rise, par;
  logic [CW-1:0] base;
  logic [SW-1:0] sum;
  logic emit_need;
  rng_t in_rng;

  // marks only on a word step past the first points
  always_comb begin
    cnt_inc = (cnt_r < CW'(MAX_POINTS)) ? cnt_r + 1'b1 : cnt_r;
    pair_ok = !fl_r && (cnt_r >= CW'(LAG));
    fall = pair_ok && f_item.fall;
    rise = pair_ok && f_item.rise;
    par  = pair_ok && !f_item.fall && !f_item.rise &&
           (prodp_r > PRODW'(cq[0].rng)) && (f_item.prod > PRODW'(cq[0].rng));
  end

  // index of the point that leaves the centre cell
  always_comb begin
    base = fl_r ? cnt_r : cnt_inc;
    sum = SW'(base) + (fl_r ? SW'(fd_r) : '0);
    emit_need = sum >= SW'(LAG + 1);
  end

  // step control
  assign step_n = f_valid && !fl_r && em_ready;
  assign fstep = fl_r && (em_ready || !emit_need);
  assign shift = step_n || fstep;
  assign fend = fstep && (fd_r == 3'(LAG));
  assign f_take = step_n;

  // cell inputs
  assign in_rng = fl_r ? '0 : f_item.rng;
  always_comb begin
    cd[0].rng = in_rng;
    cd[0].excl = pend_r[0] | rise;
    mk = '0;
    for (int k = 1; k < NCELL; k++) begin
      cd[k] = cq[k - 1];
    end
    for (int k = 1; k <= LAG; k++) begin
      mk[k] = fall;
    end
    mk[1] = fall | par;
  end

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    lcom_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (shift),
      .clr   (fend),
      .d     (cd[g]),
      .mark  (mk[g]),
      .q     (cq[g])
    );
  end

  // running sum over the cells
  assign wsum_nxt = wsum_r + WSW'(in_rng) - WSW'(cq[NCELL-1].rng);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      fl_r <= 1'b0;
      fd_r <= '0;
      pend_r <= '0;
      wsum_r <= '0;
      prodp_r <= '0;
    end else if (fend) begin
      cnt_r <= '0;
      fl_r <= 1'b0;
      fd_r <= '0;
      pend_r <= '0;
      wsum_r <= '0;
    end else if (fstep) begin
      fd_r <= fd_r + 1'b1;
      pend_r <= {1'b0, pend_r[HALF-1:1]};
      wsum_r <= wsum_nxt;
    end else if (step_n) begin
      cnt_r <= cnt_inc;
      pend_r <= {rise, pend_r[HALF-1:1] | {(HALF - 1){rise}}};
      wsum_r <= wsum_nxt;
      prodp_r <= f_item.prod;
      if (f_item.last) begin
        fl_r <= 1'b1;
        fd_r <= 3'd1;
      end
    end
  end

  // result word for the curvature pipeline
  always_comb begin
    em_valid = shift && emit_need;
    em.centre = cq[HALF].rng;
    em.wsum = wsum_r;
    em.meta.index = IDXW'(sum - SW'(LAG + 1));
    em.meta.cvalid = (sum >= SW'(LAG + 1 + HALF)) && (!fl_r || fd_r == 3'd1);
    em.meta.excl = cq[HALF].excl | fall;
    em.meta.last = fl_r && (fd_r == 3'(LAG));
  end

`ifndef SYNTHESIS
  a_fd_range: assert property (@(posedge clk) disable iff (!rst_n)
    fl_r |-> (fd_r >= 3'd1 && fd_r <= 3'(LAG)))
    else $error("flush step out of range");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fend |=> (cnt_r == '0 && pend_r == '0 && !fl_r && wsum_r == '0))
    else $error("state not cleared after flush");

  a_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_POINTS))
    else $error("point count past saturation");

  a_cvalid_index: assert property (@(posedge clk) disable iff (!rst_n)
    (em_valid && em.meta.cvalid) |-> (em.meta.index >= IDXW'(HALF)))
    else $error("valid curvature near cloud start");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/lcom_curv.sv =====
`default_nettype none

module lcom_curv import lcom_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  em_valid,
  output logic       em_ready,
  input  wire emit_t em,
  lcom_out_if.source out_res
);

  logic v1_r, v2_r, v3_r, vo_r;
  logic take_o, free3, free2, free1;

  wsum_t w1_r, r11_r;
  meta_t m1_r, m2_r, m3_r, mo_r;
  wsum_t d2_r;
  sq_t sq3_r;
  curv_t curv_o_r;
  wsum_t r11_nxt;
  wsum_t d2_nxt;

  // stage handshake
  assign take_o = !vo_r || out_res.ready;
  assign free3 = !v3_r || take_o;
  assign free2 = !v2_r || free3;
  assign free1 = !v1_r || free2;
  assign em_ready = free1;

  // eleven times the centre range
  assign r11_nxt = WSW'({em.centre, 3'b000}) + WSW'({em.centre, 1'b0}) + WSW'(em.centre);
  // neighbor sum minus ten centres
  assign d2_nxt = (w1_r >= r11_r) ? w1_r - r11_r : r11_r - w1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (free1) v1_r <= em_valid;
      if (free2) v2_r <= v1_r;
      if (free3) v3_r <= v2_r;
      if (take_o) vo_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (free1 && em_valid) begin
      w1_r <= em.wsum;
      r11_r <= r11_nxt;
      m1_r <= em.meta;
    end
    if (free2 && v1_r) begin
      d2_r <= d2_nxt;
      m2_r <= m1_r;
    end
    if (free3 && v2_r) begin
      sq3_r <= SQW'(d2_r) * SQW'(d2_r);
      m3_r <= m2_r;
    end
    if (take_o && v3_r) begin
      curv_o_r <= m3_r.cvalid ? sq3_r[CURVW-1:0] : '0;
      mo_r <= m3_r;
    end
  end

  assign out_res.valid = vo_r;
  assign out_res.point_index = mo_r.index;
  assign out_res.curvature = curv_o_r;
  assign out_res.curvature_valid = mo_r.cvalid;
  assign out_res.excluded = mo_r.excl;
  assign out_res.last_result = mo_r.last;

endmodule

`default_nettype wire

// ===== rtl/core/lidar_curvature_occlusion_marker.sv =====
// path: a point that releases a result passes the 3 front stages, the window step,
//   then the 3 curvature stages with output register
// throughput: one point per cycle while the output does not stall, set by the
//   single-step window shift; a point with last_point holds the input while the window drains
// reset: rst_n synchronous, active low; clears window, counters, valid bits,
//   and loads the configuration registers with their defaults
`default_nettype none

module lidar_curvature_occlusion_marker import lcom_pkg::*; #(
  parameter int MAX_POINTS  = 65536,
  parameter int MAX_COLUMNS = 2048
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  lcom_in_if.sink                in_pt,
  lcom_out_if.source             out_res,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  gap_t occ_gap_r;
  div_t par_div_r;
  col_t col_gap_r;
  cfg_t cfg;
  logic [1:0] reg_idx;
  logic wr_en;

  logic   f_valid, f_take;
  fitem_t f_item;
  logic   em_valid, em_ready;
  emit_t  em;

  // register file
  assign cfg_pready = 1'b1;
  assign reg_idx = cfg_paddr[CFG_AW-1:2];
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_gap_r <= OCC_GAP_RST;
      par_div_r <= PAR_DIV_RST;
      col_gap_r <= COL_GAP_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_OCC_GAP: occ_gap_r <= cfg_pwdata[GAPW-1:0];
        REG_PAR_DIV: par_div_r <= cfg_pwdata[DIVW-1:0];
        REG_COL_GAP: col_gap_r <= cfg_pwdata[COLW-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (reg_idx)
      REG_OCC_GAP: cfg_prdata = CFG_DW'(occ_gap_r);
      REG_PAR_DIV: cfg_prdata = CFG_DW'(par_div_r);
      REG_COL_GAP: cfg_prdata = CFG_DW'(col_gap_r);
      default:     cfg_prdata = '0;
    endcase
  end

  assign cfg.occ_gap = occ_gap_r;
  assign cfg.par_div = par_div_r;
  assign cfg.col_gap = col_gap_r;

  lcom_front #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_pt   (in_pt),
    .f_valid (f_valid),
    .f_take  (f_take),
    .f_item  (f_item)
  );

  lcom_chain #(
    .MAX_POINTS (MAX_POINTS)
  ) u_chain (
    .clk      (clk),
    .rst_n    (rst_n),
    .f_valid  (f_valid),
    .f_take   (f_take),
    .f_item   (f_item),
    .em_valid (em_valid),
    .em_ready (em_ready),
    .em       (em)
  );

  lcom_curv u_curv (
    .clk      (clk),
    .rst_n    (rst_n),
    .em_valid (em_valid),
    .em_ready (em_ready),
    .em       (em),
    .out_res  (out_res)
  );

endmodule

`default_nettype wire

// ===== sim/tb_lidar_curvature_occlusion_marker.sv =====
`default_nettype none

module tb_lidar_curvature_occlusion_marker;
  timeunit 1ns;
  timeprecision 1ps;
  import lcom_pkg::*;

  localparam int WIN         = 12;
  localparam int MAX_PTS     = 65536;
  localparam int RNG_MAX     = 262143;
  localparam int COL_MAX     = 2047;
  localparam int SETTLE      = 16;
  localparam int HOLD_CYC    = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_PTS   = 65;
  localparam int NPHASE      = 6;
  localparam int NDIR        = 20;

  typedef struct packed {
    idx_t  index;
    curv_t curv;
    logic  cvalid;
    logic  excl;
    logic  lst;
  } mark_t;

  typedef struct {
    rng_t  rng;
    col_t  col;
    logic  lst;
    bit    typed;
    mark_t want;
  } dir_row_t;

  localparam mark_t NO_MARK = '0;

  logic clk = 1'b0;
  logic rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  wire  [CFG_DW-1:0] cfg_prdata;
  wire               cfg_pready;

  lcom_in_if  in_pt ();
  lcom_out_if out_res ();

  lidar_curvature_occlusion_marker u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_pt       (in_pt),
    .out_res     (out_res),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // predictor state: window of ranges, columns and exclusion marks
  rng_t        rng_win  [WIN];
  col_t        col_win  [WIN];
  bit          excl_win [WIN];
  int          pts_seen;
  int unsigned occ_gap_m;
  int unsigned par_div_m;
  int unsigned col_gap_m;
  mark_t       marked_q [$];

  int errors    = 0;
  int n_sent    = 0;
  int n_checked = 0;
  int n_clouds  = 0;
  int n_writes  = 0;
  int tx_idle_pct;
  int rx_idle_pct;
  logic hold_req;
  int hold_cnt  = 0;
  int stall_cnt = 0;

  function automatic void clear_window();
    for (int k = 0; k < WIN; k++) begin
      rng_win[k]  = '0;
      col_win[k]  = '0;
      excl_win[k] = 1'b0;
    end
    pts_seen = 0;
  endfunction

  // append one expected point at the tail of the scoreboard
  function automatic void queue_mark(mark_t m);
    marked_q.insert(marked_q.size(), m);
  endfunction

  // one emitted point, curvature taken around window slot centre
  function automatic mark_t window_result(int p, int centre, bit valid, bit ex, bit lst);
    longint s;
    mark_t  m;
    s = 0;
    if (valid) begin
      for (int k = centre - 5; k <= centre + 5; k++) begin
        if (k != centre) s += longint'(rng_win[k]);
      end
      s -= 10 * longint'(rng_win[centre]);
      if (s < 0) s = -s;
    end
    m.index  = idx_t'(p);
    m.curv   = curv_t'(s * s);
    m.cvalid = valid;
    m.excl   = ex;
    m.lst    = lst;
    return m;
  endfunction

  // shift one point into the window, mark occlusion and parallel points
  function automatic void advance_window(rng_t r, col_t c, logic lst, bit push);
    int     j;
    int     p;
    longint d1, d2, da, db, cd;
    bit     occ;
    for (int k = WIN - 1; k > 0; k--) begin
      rng_win[k] = rng_win[k-1];
      col_win[k] = col_win[k-1];
    end
    rng_win[0] = r;
    col_win[0] = c;
    for (int k = 0; k < WIN - 1; k++) excl_win[k] = excl_win[k+1];
    excl_win[WIN-1] = 1'b0;
    if (pts_seen < MAX_PTS) pts_seen++;
    j = pts_seen - 1;

    if (j >= 6) begin
      d1  = longint'(rng_win[1]);
      d2  = longint'(rng_win[0]);
      cd  = longint'(col_win[0]) - longint'(col_win[1]);
      if (cd < 0) cd = -cd;
      occ = 1'b0;
      if (cd < longint'(col_gap_m)) begin
        if (d1 > d2 + longint'(occ_gap_m)) begin
          for (int k = 0; k <= 5; k++) excl_win[k] = 1'b1;
          occ = 1'b1;
        end else if (d2 > d1 + longint'(occ_gap_m)) begin
          for (int k = 6; k <= 11; k++) excl_win[k] = 1'b1;
          occ = 1'b1;
        end
      end
      if (!occ) begin
        da = longint'(rng_win[2]) - d1;
        db = d2 - d1;
        if (da < 0) da = -da;
        if (db < 0) db = -db;
        if (da * longint'(par_div_m) > d1 && db * longint'(par_div_m) > d1) excl_win[5] = 1'b1;
      end
      if (push) queue_mark(window_result(j - 6, 6, (j - 6) >= 5, excl_win[0], 1'b0));
    end

    // last point flushes everything still held
    if (lst) begin
      for (int d = 1; d <= 6; d++) begin
        p = j - 6 + d;
        if (p >= 0 && push)
          queue_mark(window_result(p, 6 - d, d <= 1 && p >= 5, excl_win[d], d == 6));
      end
      clear_window();
    end
  endfunction

  function automatic void check_field(string fname, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
    end
  endfunction

  // offer one word and wait for it to be taken
  task automatic send_point(rng_t r, col_t c, logic lst, bit typed, mark_t want);
    in_pt.valid      <= 1'b1;
    in_pt.range_mm   <= r;
    in_pt.column     <= c;
    in_pt.last_point <= lst;
    @(posedge clk);
    while (!in_pt.ready) @(posedge clk);
    advance_window(r, c, lst, !typed);
    if (typed) queue_mark(want);
    n_sent++;
    if (lst) n_clouds++;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_pt.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_until_drained();
    in_pt.valid <= 1'b0;
    while (marked_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_idling(int tx, int rx);
    tx_idle_pct = tx;
    rx_idle_pct <= rx;
  endtask

  // register write followed by a read back
  task automatic write_reg(logic [1:0] ridx, int unsigned val);
    logic [CFG_DW-1:0] want;
    want = '0;
    case (ridx)
      REG_OCC_GAP: begin
        occ_gap_m = val & 32'hFFFF;
        want      = occ_gap_m;
      end
      REG_PAR_DIV: begin
        par_div_m = val & 32'h3FF;
        want      = par_div_m;
      end
      REG_COL_GAP: begin
        col_gap_m = val & 32'h7FF;
        want      = col_gap_m;
      end
      default: want = '0;
    endcase
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {ridx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== want) begin
      errors++;
      $display("%0t: register %0d read back, expected %0d, got %0d",
               $time, ridx, want, cfg_prdata);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    n_writes++;
  endtask

  // one cloud: mostly smooth surfaces with steps, column jumps and noise
  task automatic random_cloud(int len, bit pause_mid);
    int r;
    int c;
    r = $urandom_range(0, RNG_MAX);
    c = $urandom_range(0, COL_MAX);
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(0, 9))
        0: r = $urandom_range(0, RNG_MAX);
        1: r = r + int'($urandom_range(0, 2 * occ_gap_m + 400)) - int'(occ_gap_m) - 200;
        2: c = $urandom_range(0, COL_MAX);
        3: c = (c + int'(col_gap_m)) % (COL_MAX + 1);
        default: begin
          r = r + int'($urandom_range(0, 60)) - 30;
          c = (c + int'($urandom_range(0, 2))) % (COL_MAX + 1);
        end
      endcase
      if (r < 0) r = 0;
      if (r > RNG_MAX) r = RNG_MAX;
      send_point(rng_t'(r), col_t'(c), k == len - 1, 1'b0, NO_MARK);
      if (pause_mid && k == len / 2) wait_until_drained();
    end
  endtask

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_req && hold_cnt < HOLD_CYC) begin
      out_res.ready <= 1'b0;
      hold_cnt      <= hold_cnt + 1;
    end else begin
      if (!hold_req) hold_cnt <= 0;
      out_res.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // compare each result word with the oldest expected point
  always @(posedge clk) begin
    mark_t want;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (marked_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got index %0d",
                 $time, out_res.point_index);
      end else begin
        want = marked_q.pop_front();
        check_field("point_index", want.index, out_res.point_index);
        check_field("curvature", want.curv, out_res.curvature);
        check_field("curvature_valid", want.cvalid, out_res.curvature_valid);
        check_field("excluded", want.excl, out_res.excluded);
        check_field("last_result", want.lst, out_res.last_result);
        n_checked++;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_pt.valid && in_pt.ready) || (out_res.valid && out_res.ready))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, marked_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  dir_row_t    dir_rows [NDIR];
  int unsigned occ_set  [NPHASE] = '{300, 0, 65535, 150, 40, 1000};
  int unsigned div_set  [NPHASE] = '{50, 1, 1000, 0, 20, 3};
  int unsigned colg_set [NPHASE] = '{10, 2047, 0, 5, 1, 64};

  initial begin
    int start;
    int len;

    rst_n            <= 1'b0;
    in_pt.valid      <= 1'b0;
    in_pt.range_mm   <= '0;
    in_pt.column     <= '0;
    in_pt.last_point <= 1'b0;
    cfg_psel         <= 1'b0;
    cfg_penable      <= 1'b0;
    cfg_pwrite       <= 1'b0;
    cfg_paddr        <= '0;
    cfg_pwdata       <= '0;
    hold_req         <= 1'b0;
    set_idling(7, 82);
    occ_gap_m = OCC_GAP_RST;
    par_div_m = PAR_DIV_RST;
    col_gap_m = COL_GAP_RST;
    clear_window();

    // directed clouds at reset settings
    dir_rows = '{
      '{18'd262143, 11'd2047, 1'b1, 1'b1, '{16'd0, 43'd0, 1'b0, 1'b0, 1'b1}},
      '{18'd0,      11'd0,    1'b0, 1'b0, NO_MARK},
      '{18'd131072, 11'd1,    1'b0, 1'b0, NO_MARK},
      '{18'd262143, 11'd2,    1'b1, 1'b0, NO_MARK},
      '{18'd1000,   11'd0,    1'b0, 1'b0, NO_MARK},
      '{18'd1000,   11'd1,    1'b0, 1'b0, NO_MARK},
      '{18'd1000,   11'd2,    1'b0, 1'b0, NO_MARK},
      '{18'd1000,   11'd3,    1'b0, 1'b0, NO_MARK},
      '{18'd1000,   11'd4,    1'b0, 1'b0, NO_MARK},
      '{18'd1000,   11'd5,    1'b0, 1'b0, NO_MARK},
      '{18'd1000,   11'd6,    1'b0, 1'b1, '{16'd0, 43'd0, 1'b0, 1'b0, 1'b0}},
      '{18'd1000,   11'd7,    1'b0, 1'b1, '{16'd1, 43'd0, 1'b0, 1'b0, 1'b0}},
      // step up: far side marks itself forward
      '{18'd2000,   11'd8,    1'b0, 1'b1, '{16'd2, 43'd0, 1'b0, 1'b0, 1'b0}},
      // step down: far side marks itself backward
      '{18'd500,    11'd9,    1'b0, 1'b1, '{16'd3, 43'd0, 1'b0, 1'b1, 1'b0}},
      '{18'd500,    11'd30,   1'b0, 1'b0, NO_MARK},
      '{18'd900,    11'd31,   1'b0, 1'b0, NO_MARK},
      '{18'd1000,   11'd32,   1'b0, 1'b0, NO_MARK},
      '{18'd950,    11'd33,   1'b0, 1'b0, NO_MARK},
      // beam-parallel point between two close steps
      '{18'd1010,   11'd34,   1'b0, 1'b0, NO_MARK},
      // column step equal to the gap, then flush
      '{18'd5000,   11'd44,   1'b1, 1'b0, NO_MARK}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_point(dir_rows[i].rng, dir_rows[i].col, dir_rows[i].lst,
                 dir_rows[i].typed, dir_rows[i].want);

    // random clouds over several register settings and idling mixes
    for (int ph = 0; ph < NPHASE; ph++) begin
      case (ph / 2)
        0:       set_idling(7, 82);
        1:       set_idling(82, 7);
        default: set_idling(0, 0);
      endcase
      if (ph > 0) begin
        wait_until_drained();
        write_reg(REG_OCC_GAP, occ_set[ph]);
        write_reg(REG_PAR_DIV, div_set[ph]);
        write_reg(REG_COL_GAP, colg_set[ph]);
      end
      start = n_sent;
      // output held off long enough to back up the input
      if (ph == 4) begin
        hold_req <= 1'b1;
        random_cloud(60, 1'b0);
        hold_req <= 1'b0;
      end
      while (n_sent - start < PHASE_PTS) begin
        if ($urandom_range(99) < 15) len = $urandom_range(1, 7);
        else len = $urandom_range(8, 40);
        random_cloud(len, len > 6 && $urandom_range(99) < 10);
      end
    end

    wait_until_drained();
    $display("covered %0d points in %0d clouds, %0d results checked, %0d register writes",
             n_sent, n_clouds, n_checked, n_writes);
    $display("settings included gap and divisor extremes, divisor zero, short clouds %s",
             "and a long output hold-off");
    if (errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== lidar_curvature_occlusion_marker.f =====
rtl/core/lcom_pkg.sv
rtl/core/lcom_if.sv
rtl/core/lcom_front.sv
rtl/core/lcom_cell.sv
rtl/core/lcom_chain.sv
rtl/core/lcom_curv.sv
rtl/core/lidar_curvature_occlusion_marker.sv
sim/tb_lidar_curvature_occlusion_marker.sv
